/* rtl/blpf_pkg.sv */
`default_nettype none

package blpf_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned BYTES_W = 32;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/byte_limited_pull_fifo.sv */
// Byte-limited drop-tail packet queue with a pull handshake from the server.
// Input channel (i_in_valid / o_in_stall): one item per transfer, either a
// packet arrival (i_func = 0, id and length) or a server request (i_func = 1).
// Output channel (o_out_valid / i_out_stall): exactly one result per input
// item, carrying the emitted head packet if any, drop and request-error
// flags, and the queue occupancy and discard count after that item.
// Configuration channel (i_cfg_valid / o_cfg_ready): writes max_bytes; ready
// is always high. Write it only while no item is in flight.
// Timing: an item is taken in the idle cycle, the packet store (one
// synchronous RAM, registered read, one write and one read port) is written
// and read in that same cycle, the result register loads in the next cycle
// and the result is then offered in the output state until the receiver
// takes it; only then is a new item accepted. An arrival that lands in an
// empty queue with a request waiting is forwarded around the RAM.
// While the receiver stalls the result holds and o_in_stall stays high.
// Reset (synchronous, active low) empties the queue, clears the pending
// request and discard count, and sets max_bytes to all ones. The RAM itself
// is not cleared; only written entries are ever read.
`default_nettype none

module byte_limited_pull_fifo #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [blpf_pkg::BYTES_W-1:0]        i_cfg_data,
    // input items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_func,
    input  wire logic [blpf_pkg::ID_W-1:0]           i_packet_id,
    input  wire logic [blpf_pkg::LEN_W-1:0]          i_packet_bytes,
    // results
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_emit_valid,
    output logic [blpf_pkg::ID_W-1:0]                o_emit_id,
    output logic [blpf_pkg::LEN_W-1:0]               o_emit_bytes,
    output logic                                     o_dropped,
    output logic                                     o_request_error,
    output logic [blpf_pkg::BYTES_W-1:0]             o_queued_bytes,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         o_queued_packets,
    output logic [blpf_pkg::BYTES_W-1:0]             o_discard_total
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BW    = blpf_pkg::BYTES_W;

    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    blpf_pkg::t_state r_state, n_state;

    logic [BW-1:0]    r_max_bytes;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [BW-1:0]    r_bytes, n_bytes;
    logic             r_pending, n_pending;
    logic [BW-1:0]    r_discard, n_discard;

    // per-item flags carried from the accept cycle to the read cycle
    logic             r_emit, n_emit;
    logic             r_fwd, n_fwd;
    logic             r_drop, n_drop;
    logic             r_req_err, n_req_err;
    blpf_pkg::t_entry r_fwd_entry;

    // result register
    logic             r_out_emit;
    blpf_pkg::t_entry r_out_entry;
    logic             r_out_drop;
    logic             r_out_req_err;
    logic [BW-1:0]    r_out_bytes;
    logic [CNT_W-1:0] r_out_count;
    logic [BW-1:0]    r_out_discard;

    // packet store
    blpf_pkg::t_entry r_mem [QUEUE_DEPTH];
    blpf_pkg::t_entry r_rd_data;
    logic             mem_wr_en;
    logic             mem_rd_en;
    blpf_pkg::t_entry wr_entry;

    logic             in_xfer;
    logic             out_xfer;
    logic [BW:0]      sum;
    logic             refuse;
    logic             append;
    logic             pend_next;
    logic             emit_now;
    blpf_pkg::t_entry emit_entry;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != blpf_pkg::S_IDLE);
    assign o_out_valid = (r_state == blpf_pkg::S_OUT);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;

    assign sum       = {1'b0, r_bytes} + (BW+1)'(i_packet_bytes);
    assign refuse    = (sum >= {1'b0, r_max_bytes}) || (r_count == FULL_CNT);
    assign append    = (i_func == blpf_pkg::FUNC_ARRIVAL) && !refuse;
    assign pend_next = (i_func == blpf_pkg::FUNC_REQUEST) || r_pending;
    assign emit_now  = pend_next && ((r_count != '0) || append);

    assign wr_entry.id  = i_packet_id;
    assign wr_entry.len = i_packet_bytes;
    assign mem_wr_en    = in_xfer && append;
    assign mem_rd_en    = in_xfer && emit_now;

    assign emit_entry = r_fwd ? r_fwd_entry : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[r_tail] <= wr_entry;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_bytes   = r_bytes;
        n_pending = r_pending;
        n_discard = r_discard;
        n_emit    = r_emit;
        n_fwd     = r_fwd;
        n_drop    = r_drop;
        n_req_err = r_req_err;
        unique case (r_state)
            blpf_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state   = blpf_pkg::S_READ;
                    n_emit    = emit_now;
                    // empty queue: the head is the arriving packet itself
                    n_fwd     = (r_count == '0);
                    n_drop    = (i_func == blpf_pkg::FUNC_ARRIVAL) && refuse;
                    n_req_err = (i_func == blpf_pkg::FUNC_REQUEST) && r_pending;
                    n_pending = pend_next && !emit_now;
                    n_count   = r_count + CNT_W'(append) - CNT_W'(emit_now);
                    if (n_drop) begin
                        n_discard = r_discard + BW'(1);
                    end
                    if (append) begin
                        n_bytes = sum[BW-1:0];
                        n_tail  = (r_tail == LAST_PTR) ? '0 : r_tail + PTR_W'(1);
                    end
                    if (emit_now) begin
                        n_head = (r_head == LAST_PTR) ? '0 : r_head + PTR_W'(1);
                    end
                end
            end
            blpf_pkg::S_READ: begin
                n_state = blpf_pkg::S_OUT;
                if (r_emit) begin
                    n_bytes = r_bytes - BW'(emit_entry.len);
                end
            end
            blpf_pkg::S_OUT: begin
                if (out_xfer) begin
                    n_state = blpf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = blpf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blpf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= '1;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_pending   <= 1'b0;
            r_discard   <= '0;
            r_emit      <= 1'b0;
            r_fwd       <= 1'b0;
            r_drop      <= 1'b0;
            r_req_err   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_bytes <= i_cfg_data;
            end
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_bytes   <= n_bytes;
            r_pending <= n_pending;
            r_discard <= n_discard;
            r_emit    <= n_emit;
            r_fwd     <= n_fwd;
            r_drop    <= n_drop;
            r_req_err <= n_req_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_fwd_entry <= wr_entry;
        end
        if (r_state == blpf_pkg::S_READ) begin
            r_out_emit    <= r_emit;
            r_out_entry   <= r_emit ? emit_entry : '0;
            r_out_drop    <= r_drop;
            r_out_req_err <= r_req_err;
            r_out_bytes   <= n_bytes;
            r_out_count   <= r_count;
            r_out_discard <= r_discard;
        end
    end

    assign o_emit_valid     = r_out_emit;
    assign o_emit_id        = r_out_entry.id;
    assign o_emit_bytes     = r_out_entry.len;
    assign o_dropped        = r_out_drop;
    assign o_request_error  = r_out_req_err;
    assign o_queued_bytes   = r_out_bytes;
    assign o_queued_packets = r_out_count;
    assign o_discard_total  = r_out_discard;

`ifndef SYNTH
    // a waiting server never coexists with a non-empty queue between items
    a_no_stale_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blpf_pkg::S_IDLE) |-> !(r_pending && (r_count != '0)))
        else $error("request pending while queue holds packets");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above queue depth");

    a_emit_clears_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_emit_valid) |-> !r_pending)
        else $error("request still pending after emission");

    // a refused arrival never emits: a waiting request implies an empty queue
    a_drop_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> !o_emit_valid)
        else $error("dropped arrival also emitted a packet");

    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !in_xfer ##1 !in_xfer)
        else $error("new item taken before result was formed");
`endif

endmodule

`default_nettype wire
